[sv/mcet_pkg.sv]
// ----------------------------------------------------------------------------
// mcet_pkg: shared types and constants of the extended one-shot timer unit
// Action and status codes, divider sizing, controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package mcet_pkg;

  // default sizes handed to the top level
  localparam int NUM_CHANNELS = 4;
  localparam int COUNTER_BITS = 16;
  localparam int WRAP_BITS    = 20;

  // payload field widths
  localparam int ACTION_W = 2;
  localparam int DUR_W    = 40;
  localparam int ID_W     = 3;
  localparam int ALLOC_W  = 3;
  localparam int MASK_W   = 4;
  localparam int STATUS_W = 2;

  // us -> 32.768 kHz ticks: (dur * 1024 + 15625) / 31250
  localparam int  DUR_SHIFT  = 10;
  localparam int  NUM_W      = DUR_W + DUR_SHIFT + 1;  // numerator and quotient
  localparam int  REM_W      = 15;                     // remainder < 31250
  localparam logic [REM_W:0]   DIVISOR    = (REM_W + 1)'(31250);
  localparam logic [NUM_W-1:0] ROUND_BIAS = NUM_W'(15625);

  // long division by 16-bit digits; each digit is estimated by a reciprocal
  // multiply (true digit or one less) and then corrected
  localparam int DIGIT_W     = 16;
  localparam int NUM_DIGITS  = (NUM_W + DIGIT_W - 1) / DIGIT_W;
  localparam int PAD_W       = NUM_DIGITS * DIGIT_W;
  localparam int X_W         = REM_W + DIGIT_W;        // remainder and next digit
  localparam int STEP_CNT_W  = $clog2(NUM_DIGITS + 1);
  localparam int RECIP_SHIFT = 45;
  localparam logic [X_W-1:0] RECIP = X_W'(1125899906);  // floor(2^45 / 31250)

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_TICK  = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_BAD_ID = 2'd2
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic div_start;  // load divider with the new duration
    logic exec_now;   // action without the divider, load result
    logic commit;     // finish allocate, load result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic alloc_go;   // allocate that needs the divider
    logic div_done;
  } sts_t;

endpackage

`default_nettype wire

[sv/multi_channel_extended_oneshot_timer_unit.sv]
// ----------------------------------------------------------------------------
// multi_channel_extended_oneshot_timer_unit: four-channel one-shot timer
// Free-running counter with compare channels extended by a wrap count.
//
//   channel | dir | tdata (low bit up)                        | tuser
//   s_axis  | in  | duration_us[39:0] channel_id[42:40] pad   | action[1:0]
//   m_axis  | out | alloc_id[2:0] expired_mask[6:3] status[8:7] pad | -
//
// Free, tick and rejected allocate: result in the next cycle, back to back while
// the result side keeps up. A granted allocate runs the tick converter, which
// forms four 16-bit quotient digits, each by an estimate step and a correction
// step, then commits its result; no new transfer is taken until that commit.
// Reset clears counter and all channels; no clearing pass.
// A stalled result holds the result register; input and commit wait while it stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_extended_oneshot_timer_unit #(
  parameter int NumChannels = mcet_pkg::NUM_CHANNELS,
  parameter int CounterBits = mcet_pkg::COUNTER_BITS,
  parameter int WrapBits    = mcet_pkg::WRAP_BITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // duration_us [39:0], channel_id [42:40], zero pad [47:43]
  input  wire logic [47:0] s_axis_tdata_i,
  // action [1:0]
  input  wire logic [1:0]  s_axis_tuser_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // alloc_id [2:0], expired_mask [6:3], status [8:7], zero pad [15:9]
  output logic [15:0]      m_axis_tdata_o,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i
);

  mcet_pkg::cmd_t                      cmd;
  mcet_pkg::sts_t                      sts;
  logic [mcet_pkg::ALLOC_W-1:0]        alloc_id;
  logic [mcet_pkg::MASK_W-1:0]         expired_mask;
  logic [mcet_pkg::STATUS_W-1:0]       status;

  // sequencing: decides between immediate actions and a divider run
  mcet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // counter, channel bank, tick conversion and result register
  mcet_dp #(
    .NumChannels (NumChannels),
    .CounterBits (CounterBits),
    .WrapBits    (WrapBits)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .action_i       (s_axis_tuser_i),
    .duration_us_i  (s_axis_tdata_i[39:0]),
    .channel_id_i   (s_axis_tdata_i[42:40]),
    .alloc_id_o     (alloc_id),
    .expired_mask_o (expired_mask),
    .status_o       (status)
  );

  assign m_axis_tdata_o = {7'd0, status, expired_mask, alloc_id};

endmodule

`default_nettype wire

[sv/mcet_div.sv]
// ----------------------------------------------------------------------------
// mcet_div: microsecond to tick converter
// Long division by a fixed divisor, one 16-bit quotient digit at a time in two steps:
// reciprocal estimate, then a single compare and subtract correction.
// ----------------------------------------------------------------------------
`default_nettype none

module mcet_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [mcet_pkg::DUR_W-1:0]   dur_i,
  output logic                              done_o,
  output logic      [mcet_pkg::NUM_W-1:0]   ticks_o
);

  localparam int NumW   = mcet_pkg::NUM_W;
  localparam int RemW   = mcet_pkg::REM_W;
  localparam int CntW   = mcet_pkg::STEP_CNT_W;
  localparam int DigitW = mcet_pkg::DIGIT_W;
  localparam int PadW   = mcet_pkg::PAD_W;
  localparam int XW     = mcet_pkg::X_W;
  localparam int ProdW  = 2 * XW;
  localparam int ChkW   = 2 * DigitW;

  logic [PadW-1:0]   num_q, num_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              fix_phase_q, fix_phase_d;
  logic [DigitW-1:0] est_q, est_d;
  logic [NumW-1:0]   load_val;
  logic [XW-1:0]     x;
  logic [ProdW-1:0]  est_prod;
  logic [ChkW-1:0]   chk_prod;
  logic [ChkW-1:0]   diff;
  logic [DigitW-1:0] diff_lo;
  logic              fix;
  logic [DigitW-1:0] q_digit;
  logic [DigitW-1:0] rem_next;

  assign load_val = NumW'({dur_i, {mcet_pkg::DUR_SHIFT{1'b0}}}) + mcet_pkg::ROUND_BIAS;

  // partial dividend: running remainder followed by the next digit
  assign x        = {rem_q, num_q[PadW-1 -: DigitW]};
  assign est_prod = ProdW'(x) * ProdW'(mcet_pkg::RECIP);

  // estimate is the true digit or one less
  assign chk_prod = ChkW'(est_q) * ChkW'(mcet_pkg::DIVISOR);
  assign diff     = ChkW'(x) - chk_prod;
  assign diff_lo  = diff[DigitW-1:0];
  assign fix      = (diff_lo >= mcet_pkg::DIVISOR);
  assign q_digit  = est_q + DigitW'(fix);
  assign rem_next = fix ? diff_lo - mcet_pkg::DIVISOR : diff_lo;

  always_comb begin
    num_d       = num_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    fix_phase_d = fix_phase_q;
    est_d       = est_q;
    if (start_i) begin
      num_d       = PadW'(load_val);
      rem_d       = '0;
      cnt_d       = CntW'(mcet_pkg::NUM_DIGITS);
      fix_phase_d = 1'b0;
    end else if (cnt_q != '0) begin
      if (!fix_phase_q) begin
        est_d       = est_prod[mcet_pkg::RECIP_SHIFT +: DigitW];
        fix_phase_d = 1'b1;
      end else begin
        // quotient digits shift in behind the numerator digits
        num_d       = {num_q[PadW-DigitW-1:0], q_digit};
        rem_d       = rem_next[RemW-1:0];
        cnt_d       = cnt_q - CntW'(1);
        fix_phase_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      fix_phase_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      fix_phase_q <= fix_phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    est_q <= est_d;
  end

  assign done_o  = (cnt_q == '0);
  assign ticks_o = num_q[NumW-1:0];

endmodule

`default_nettype wire

[sv/mcet_dp.sv]
// ----------------------------------------------------------------------------
// mcet_dp: timer datapath
// Free-running counter, channel bank, tick converter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mcet_dp #(
  parameter int NumChannels = mcet_pkg::NUM_CHANNELS,
  parameter int CounterBits = mcet_pkg::COUNTER_BITS,
  parameter int WrapBits    = mcet_pkg::WRAP_BITS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire mcet_pkg::cmd_t                  cmd_i,
  output mcet_pkg::sts_t                       sts_o,
  input  wire logic [mcet_pkg::ACTION_W-1:0]   action_i,
  input  wire logic [mcet_pkg::DUR_W-1:0]      duration_us_i,
  input  wire logic [mcet_pkg::ID_W-1:0]       channel_id_i,
  output logic      [mcet_pkg::ALLOC_W-1:0]    alloc_id_o,
  output logic      [mcet_pkg::MASK_W-1:0]     expired_mask_o,
  output logic      [mcet_pkg::STATUS_W-1:0]   status_o
);

  localparam int NumW   = mcet_pkg::NUM_W;
  localparam int IdxW   = (NumChannels > 1) ? $clog2(NumChannels) : 1;
  localparam int MaskW  = mcet_pkg::MASK_W;
  localparam int AllocW = mcet_pkg::ALLOC_W;
  localparam int SumW   = IdxW + AllocW;

  logic [CounterBits-1:0] counter_q, counter_d, counter_inc;
  logic [NumChannels-1:0] in_use_q, in_use_d;
  logic [NumChannels-1:0] armed_q, armed_d;
  logic [CounterBits-1:0] compare_q [NumChannels];
  logic [CounterBits-1:0] compare_d [NumChannels];
  logic [WrapBits-1:0]    wraps_q   [NumChannels];
  logic [WrapBits-1:0]    wraps_d   [NumChannels];
  logic [CounterBits-1:0] residue_q [NumChannels];
  logic [CounterBits-1:0] residue_d [NumChannels];

  logic [AllocW-1:0]            alloc_id_q, alloc_id_d;
  logic [MaskW-1:0]             mask_q, mask_d;
  mcet_pkg::status_e            status_q, status_d;

  mcet_pkg::action_e            action;
  logic                         div_done;
  logic [NumW-1:0]              ticks_raw, ticks;
  logic [NumW-1:0]              whole;
  logic                         wrap_ovf;
  logic [WrapBits-1:0]          new_wraps;
  logic [CounterBits-1:0]       new_res;
  logic [CounterBits-1:0]       new_cmp;
  logic                         any_free;
  logic [IdxW-1:0]              free_idx;
  logic [SumW-1:0]              id_plus;
  logic [NumChannels-1:0]       expired;
  logic [NumChannels+MaskW-1:0] expired_ext;

  assign action = mcet_pkg::action_e'(action_i);

  mcet_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .dur_i   (duration_us_i),
    .done_o  (div_done),
    .ticks_o (ticks_raw)
  );

  // lowest free channel
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int c = NumChannels - 1; c >= 0; c--) begin
      if (!in_use_q[c]) begin
        any_free = 1'b1;
        free_idx = IdxW'(c);
      end
    end
  end

  assign sts_o.alloc_go = (action == mcet_pkg::ACT_ALLOC) && (duration_us_i != '0) && any_free;
  assign sts_o.div_done = div_done;

  // split the tick count into wraps plus residue
  assign ticks    = (ticks_raw == '0) ? NumW'(1) : ticks_raw;
  assign whole    = ticks >> CounterBits;
  assign wrap_ovf = ((whole >> WrapBits) != '0);

  always_comb begin
    if (wrap_ovf) begin
      new_wraps = '1;
      new_res   = '1;
    end else begin
      new_res   = ticks[CounterBits-1:0];
      new_wraps = (new_res == '0) ? WrapBits'(whole) - WrapBits'(1) : WrapBits'(whole);
    end
  end

  assign new_cmp     = counter_q + ((new_wraps != '0) ? '0 : new_res);
  assign counter_inc = counter_q + CounterBits'(1);
  assign id_plus     = SumW'(free_idx) + SumW'(1);
  assign expired_ext = {{MaskW{1'b0}}, expired};

  always_comb begin
    counter_d  = counter_q;
    in_use_d   = in_use_q;
    armed_d    = armed_q;
    compare_d  = compare_q;
    wraps_d    = wraps_q;
    residue_d  = residue_q;
    alloc_id_d = alloc_id_q;
    mask_d     = mask_q;
    status_d   = status_q;
    expired    = '0;

    if (cmd_i.commit) begin
      in_use_d[free_idx]  = 1'b1;
      armed_d[free_idx]   = 1'b1;
      wraps_d[free_idx]   = new_wraps;
      residue_d[free_idx] = new_res;
      compare_d[free_idx] = new_cmp;
      alloc_id_d          = id_plus[AllocW-1:0];
      mask_d              = '0;
      status_d            = mcet_pkg::ST_OK;
    end else if (cmd_i.exec_now) begin
      alloc_id_d = '0;
      mask_d     = '0;
      status_d   = mcet_pkg::ST_OK;
      case (action)
        mcet_pkg::ACT_ALLOC: begin
          // zero duration or no channel free
          status_d = mcet_pkg::ST_REJECT;
        end
        mcet_pkg::ACT_FREE: begin
          if (int'(channel_id_i) > NumChannels) begin
            status_d = mcet_pkg::ST_BAD_ID;
          end else begin
            for (int c = 0; c < NumChannels; c++) begin
              if (int'(channel_id_i) == c + 1) begin
                in_use_d[c]  = 1'b0;
                armed_d[c]   = 1'b0;
                compare_d[c] = '0;
                wraps_d[c]   = '0;
                residue_d[c] = '0;
              end
            end
          end
        end
        mcet_pkg::ACT_TICK: begin
          counter_d = counter_inc;
          for (int c = 0; c < NumChannels; c++) begin
            if (armed_q[c] && (compare_q[c] == counter_inc)) begin
              if (wraps_q[c] > WrapBits'(1)) begin
                wraps_d[c] = wraps_q[c] - WrapBits'(1);
              end else if (wraps_q[c] == WrapBits'(1)) begin
                wraps_d[c]   = '0;
                compare_d[c] = residue_q[c] + counter_inc;
              end else begin
                residue_d[c] = '0;
                armed_d[c]   = 1'b0;
                expired[c]   = 1'b1;
              end
            end
          end
          mask_d = expired_ext[MaskW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q <= '0;
      in_use_q  <= '0;
      armed_q   <= '0;
      for (int c = 0; c < NumChannels; c++) begin
        compare_q[c] <= '0;
        wraps_q[c]   <= '0;
        residue_q[c] <= '0;
      end
    end else begin
      counter_q <= counter_d;
      in_use_q  <= in_use_d;
      armed_q   <= armed_d;
      compare_q <= compare_d;
      wraps_q   <= wraps_d;
      residue_q <= residue_d;
    end
  end

  always_ff @(posedge clk_i) begin
    alloc_id_q <= alloc_id_d;
    mask_q     <= mask_d;
    status_q   <= status_d;
  end

  assign alloc_id_o     = alloc_id_q;
  assign expired_mask_o = mask_q;
  assign status_o       = status_q;

endmodule

`default_nettype wire

[sv/mcet_ctrl.sv]
// ----------------------------------------------------------------------------
// mcet_ctrl: timer controller
// Handshakes, divider sequencing and result register valid.
// ----------------------------------------------------------------------------
`default_nettype none

module mcet_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire mcet_pkg::sts_t  sts_i,
  output mcet_pkg::cmd_t       cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_DIV
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;
  logic   accept;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && slot_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (sts_i.alloc_go) begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIV;
          end else begin
            cmd_o.exec_now = 1'b1;
            out_valid_d    = 1'b1;
          end
        end
      end
      S_DIV: begin
        if (sts_i.div_done && slot_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[tb/oneshot_timer_checker.sv]
// ----------------------------------------------------------------------------
// oneshot_timer_checker: result checker for the one-shot timer unit
// Watches both stream channels, keeps a shadow copy of the counter and the
// channel state, predicts the result of each accepted transfer and compares
// the returned results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module oneshot_timer_checker
  import mcet_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [47:0] s_axis_tdata_i,
  input  wire logic [1:0]  s_axis_tuser_i,
  input  wire logic        s_axis_tvalid_i,
  input  wire logic        s_axis_tready_i,
  input  wire logic [15:0] m_axis_tdata_i,
  input  wire logic        m_axis_tvalid_i,
  input  wire logic        m_axis_tready_i,
  output int               errors_o,
  output int               pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH = NUM_CHANNELS;
  localparam int CB  = COUNTER_BITS;
  localparam int WB  = WRAP_BITS;

  typedef struct packed {
    logic [ALLOC_W-1:0] alloc_id;
    logic [MASK_W-1:0]  expired;
    status_e            status;
  } timer_outcome_t;

  timer_outcome_t outcome_q[$];
  int             err_cnt;

  // shadow timer state
  logic [CB-1:0]  tick_count;
  logic [NCH-1:0] chan_busy;
  logic [NCH-1:0] chan_live;
  logic [CB-1:0]  match_at  [NCH];
  logic [WB-1:0]  wraps_due [NCH];
  logic [CB-1:0]  tail_ticks[NCH];

  task automatic predict_timer_outcome(input  logic [ACTION_W-1:0] act,
                                       input  logic [DUR_W-1:0]    dur,
                                       input  logic [ID_W-1:0]     id,
                                       output timer_outcome_t      res);
    logic [63:0]   ticks;
    logic [63:0]   whole;
    logic [WB-1:0] wraps;
    logic [CB-1:0] rem;
    int            slot;
    res  = '{alloc_id: '0, expired: '0, status: ST_OK};
    slot = -1;
    case (act)
      ACT_ALLOC: begin
        for (int c = NCH - 1; c >= 0; c--) begin
          if (!chan_busy[c]) slot = c;
        end
        if (dur == '0 || slot < 0) begin
          res.status = ST_REJECT;
        end else begin
          // round to nearest 32.768 kHz tick, halves up
          ticks = ({{(64 - DUR_W){1'b0}}, dur} * 64'd1024 + 64'd15625) / 64'd31250;
          if (ticks == 0) ticks = 64'd1;
          whole = ticks >> CB;
          if (whole > {{(64 - WB){1'b0}}, {WB{1'b1}}}) begin
            wraps = '1;
            rem   = '1;
          end else begin
            wraps = whole[WB-1:0];
            rem   = ticks[CB-1:0];
            // a zero tail counts as one full wrap
            if (rem == '0) wraps = wraps - 1'b1;
          end
          chan_busy[slot]  = 1'b1;
          chan_live[slot]  = 1'b1;
          wraps_due[slot]  = wraps;
          tail_ticks[slot] = rem;
          match_at[slot]   = tick_count + ((wraps != '0) ? '0 : rem);
          res.alloc_id     = ALLOC_W'(slot + 1);
        end
      end
      ACT_FREE: begin
        if (id != '0) begin
          if (id > NCH) begin
            res.status = ST_BAD_ID;
          end else begin
            chan_busy[id-1]  = 1'b0;
            chan_live[id-1]  = 1'b0;
            match_at[id-1]   = '0;
            wraps_due[id-1]  = '0;
            tail_ticks[id-1] = '0;
          end
        end
      end
      ACT_TICK: begin
        tick_count = tick_count + 1'b1;
        for (int c = 0; c < NCH; c++) begin
          if (chan_live[c] && match_at[c] == tick_count) begin
            if (wraps_due[c] > 1) begin
              wraps_due[c] = wraps_due[c] - 1'b1;
            end else if (wraps_due[c] == 1) begin
              wraps_due[c] = '0;
              match_at[c]  = tail_ticks[c] + tick_count;
            end else begin
              tail_ticks[c]  = '0;
              chan_live[c]   = 1'b0;
              res.expired[c] = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    timer_outcome_t want;
    timer_outcome_t got;
    if (!rst_ni) begin
      outcome_q.delete();
      err_cnt    = 0;
      tick_count = '0;
      chan_busy  = '0;
      chan_live  = '0;
      for (int c = 0; c < NCH; c++) begin
        match_at[c]   = '0;
        wraps_due[c]  = '0;
        tail_ticks[c] = '0;
      end
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      // results first: a result never stems from the transfer taken at this edge
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = '{alloc_id: m_axis_tdata_i[2:0], expired: m_axis_tdata_i[6:3],
                status: status_e'(m_axis_tdata_i[8:7])};
        if (outcome_q.size() == 0) begin
          err_cnt++;
          $display("%t: result with nothing pending, expected none actual %h",
                   $time, m_axis_tdata_i);
        end else begin
          want = outcome_q.pop_front();
          if (got.alloc_id != want.alloc_id) begin
            err_cnt++;
            $display("%t: alloc_id expected %0d actual %0d",
                     $time, want.alloc_id, got.alloc_id);
          end
          if (got.expired != want.expired) begin
            err_cnt++;
            $display("%t: expired_mask expected %b actual %b",
                     $time, want.expired, got.expired);
          end
          if (got.status != want.status) begin
            err_cnt++;
            $display("%t: status expected %0d actual %0d",
                     $time, want.status, got.status);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_timer_outcome(s_axis_tuser_i, s_axis_tdata_i[DUR_W-1:0],
                              s_axis_tdata_i[DUR_W+ID_W-1:DUR_W], want);
        outcome_q.push_back(want);
      end
      pending_o <= outcome_q.size();
      errors_o  <= err_cnt;
    end
  end

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the extended one-shot timer unit
// Drives allocate, free and tick transfers with random idling on both sides,
// a long result-side hold-off and wrap-extension allocates; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import mcet_pkg::*;

  // code the block must ignore; not part of action_e
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  // durations in microseconds and what they turn into
  localparam logic [DUR_W-1:0] DUR_MAX       = '1;              // largest wrap count
  localparam logic [DUR_W-1:0] DUR_TINY      = 40'd1;           // rounds to zero ticks
  localparam logic [DUR_W-1:0] DUR_BELOW_ONE = 40'd15;          // still rounds to zero
  localparam logic [DUR_W-1:0] DUR_ONE_TICK  = 40'd16;          // rounds up to one tick
  localparam logic [DUR_W-1:0] DUR_ONE_WRAP  = 40'd2_000_000;   // 65536 ticks, zero tail
  localparam logic [DUR_W-1:0] DUR_TWO_WRAPS = 40'd4_000_000;   // 131072 ticks, zero tail
  localparam logic [DUR_W-1:0] DUR_TWO_PLUS  = 40'd4_000_092;   // 131075 ticks, tail of 3
  localparam int               WRAP_TICKS    = 30;              // short tail expires

  localparam int RANDOM_ITEMS = 500;
  localparam int HOLD_AT      = 200;   // result side holds off here
  localparam int DRAIN_AT     = 320;   // sender waits for every result here
  localparam int CALM_AT      = 420;   // no idling from here on
  localparam int LONG_HOLD    = 300;   // cycles of the long result-side hold-off
  localparam int SETTLE       = 100;   // covers a granted allocate
  localparam int IDLE_LIMIT   = 4000;  // cycles without any transfer

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic [47:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;

  int   errors;
  int   pending;
  int   idle_cycles = 0;
  logic hold_req = 1'b0;   // stimulus asks the result side for a long hold-off
  logic calm     = 1'b0;   // end of run: neither side idles

  // sender idling comes in stretches, some of them with no gaps at all
  int send_stretch = 0;
  int send_gap_pct = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  multi_channel_extended_oneshot_timer_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready)
  );

  oneshot_timer_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_i(s_axis_tready),
    .m_axis_tdata_i (m_axis_tdata),
    .m_axis_tvalid_i(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  // watchdog: any transfer on either channel counts as progress
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("multi_channel_extended_oneshot_timer_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stall bursts, one long hold-off on request, none at the end.
  initial begin
    int   recv_stretch;
    int   recv_stall_pct;
    logic hold_taken;
    recv_stretch   = 0;
    recv_stall_pct = 0;
    hold_taken     = 1'b0;
    m_axis_tready  = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_taken) begin
        // block fills up behind the held result and stalls its input
        hold_taken    = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        if (recv_stretch == 0) begin
          recv_stretch   = $urandom_range(16, 64);
          recv_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
        end
        recv_stretch--;
        if (!calm && $urandom_range(1, 100) <= recv_stall_pct) begin
          m_axis_tready <= 1'b0;
          repeat ($urandom_range(1, 11)) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Optional gap after a transfer; tvalid drops only when a gap is taken.
  task automatic sender_idle();
    if (calm) return;
    if (send_stretch == 0) begin
      send_stretch = $urandom_range(8, 40);
      send_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
    end
    send_stretch--;
    if ($urandom_range(1, 100) <= send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  // One input transfer; returns at the edge where it was taken, or after the gap behind it.
  task automatic offer(input logic [ACTION_W-1:0] act, input logic [DUR_W-1:0] dur,
                       input logic [ID_W-1:0] id);
    s_axis_tdata  <= {{(48 - DUR_W - ID_W){1'b0}}, id, dur};
    s_axis_tuser  <= act;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sender_idle();
  endtask

  // Tick with junk in the unused fields: the block must ignore them.
  task automatic offer_tick();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    offer(ACT_TICK, raw[DUR_W-1:0], raw[DUR_W+ID_W-1:DUR_W]);
  endtask

  // Stop offering and wait until the checker has seen every result.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Random action; allocate delays mostly expire within a few ticks, some huge, some zero.
  task automatic offer_random();
    int          r;
    logic [63:0] raw;
    logic [DUR_W-1:0] dur;
    logic [ID_W-1:0]  id;
    r   = $urandom_range(0, 99);
    raw = {$urandom, $urandom};
    dur = raw[DUR_W-1:0];
    id  = raw[DUR_W+ID_W-1:DUR_W];
    if (r < 45) begin
      offer(ACT_TICK, dur, id);
    end else if (r < 72) begin
      case ($urandom_range(0, 19))
        0, 1:    dur = '0;
        2, 3:    ;                                     // full-range duration
        4:       dur = DUR_W'($urandom_range(1, 4_000_000));
        default: dur = DUR_W'($urandom_range(1, 700));  // up to ~23 ticks
      endcase
      offer(ACT_ALLOC, dur, id);
    end else if (r < 95) begin
      if ($urandom_range(0, 7) != 0) id = ID_W'($urandom_range(1, NUM_CHANNELS));
      offer(ACT_FREE, dur, id);
    end else begin
      offer(ACT_UNUSED, dur, id);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_TICK;
    s_axis_tvalid = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed: rejects, bad ids, rounding, all channels busy ---
    offer(ACT_ALLOC, '0, '0);             // zero duration rejected
    offer(ACT_FREE, '0, 3'd0);            // id zero ignored
    offer(ACT_FREE, '0, 3'd5);            // bad id
    offer(ACT_FREE, '0, 3'd7);            // bad id, all id bits set
    offer(ACT_FREE, '0, 3'd1);            // free of an idle channel
    offer(ACT_UNUSED, DUR_MAX, '1);       // unused action code
    offer(ACT_ALLOC, DUR_TINY, '0);       // rounds to zero, takes one tick
    offer_tick();                         // channel 1 expires
    offer_tick();                         // expired channel stays claimed
    offer(ACT_ALLOC, DUR_MAX, '0);        // channel 2, maximum wrap count
    offer(ACT_ALLOC, DUR_BELOW_ONE, '0);  // channel 3
    offer(ACT_ALLOC, DUR_ONE_TICK, '0);   // channel 4
    offer(ACT_ALLOC, 40'd30, '0);         // none free
    offer_tick();                         // channels 3 and 4 expire together
    for (int c = 1; c <= NUM_CHANNELS; c++) offer(ACT_FREE, '0, ID_W'(c));
    wait_for_results();

    // --- wrap extension: zero tails, several wraps, tail after wraps ---
    offer(ACT_ALLOC, DUR_ONE_WRAP, '0);
    offer(ACT_ALLOC, DUR_TWO_WRAPS, '0);
    offer(ACT_ALLOC, DUR_TWO_PLUS, '0);
    offer(ACT_ALLOC, 40'd700, '0);
    for (int n = 0; n < WRAP_TICKS; n++) offer_tick();
    for (int c = 1; c <= NUM_CHANNELS; c++) offer(ACT_FREE, '0, ID_W'(c));
    wait_for_results();

    // --- random mix ---
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == HOLD_AT) hold_req <= 1'b1;
      if (n == DRAIN_AT) wait_for_results();
      if (n == CALM_AT) calm <= 1'b1;
      offer_random();
    end
    wait_for_results();
    repeat (SETTLE) @(posedge clk_i);

    if (errors == 0 && pending == 0) begin
      $display("multi_channel_extended_oneshot_timer_unit test passed");
    end else begin
      $display("multi_channel_extended_oneshot_timer_unit test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
